[sv/mwee_pkg.sv]
// Shared types and constants for the three-wire serial EEPROM master.
package mwee_pkg;

    // Default geometry: 16-bit word mode with 6-bit word addresses.
    localparam int ADDRESS_BITS_DEF = 6;
    localparam int DATA_BITS_DEF    = 16;

    localparam int ADDR_W    = 6;
    localparam int WDATA_W   = 16;
    localparam int RDATA_W   = 16;
    localparam int RETRIES_W = 4;

    localparam logic [RETRIES_W-1:0] READ_RETRIES_RST = 4'd10;

    // Command codes on the op field.
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_READ  = 3'd1;
    localparam logic [2:0] OP_WRITE = 3'd2;
    localparam logic [2:0] OP_ERASE = 3'd3;
    localparam logic [2:0] OP_ERAL  = 3'd4;
    localparam logic [2:0] OP_EWEN  = 3'd5;
    localparam logic [2:0] OP_EWDS  = 3'd6;

    // Two-bit opcodes sent after the start bit.
    localparam logic [1:0] OPC_READ  = 2'b10;
    localparam logic [1:0] OPC_WRITE = 2'b01;
    localparam logic [1:0] OPC_ERASE = 2'b11;
    localparam logic [1:0] OPC_EXT   = 2'b00;

    // Top two address bits that select the extended command.
    localparam logic [1:0] EXT_ERAL = 2'b10;
    localparam logic [1:0] EXT_EWEN = 2'b11;
    localparam logic [1:0] EXT_EWDS = 2'b00;

    typedef struct packed {
        logic [2:0]         op;
        logic [ADDR_W-1:0]  address;
        logic [WDATA_W-1:0] write_data;
        logic               data_out_pin;
    } in_item_t;

    typedef struct packed {
        logic               chip_select;
        logic               serial_data_in;
        logic               clock_pulse;
        logic               busy_res;
        logic               done_res;
        logic [RDATA_W-1:0] read_data;
        logic               read_failed;
    } out_item_t;

endpackage

[sv/microwire_eeprom_master.sv]
// Three-wire serial EEPROM master: command sequencer with registered result item.
//
// Each input item is one serial-clock period of the EEPROM bus; the matching
// result item gives the pin levels (chip select, data in, clock pulse) for that
// period plus busy/done/read status. Throughput is one item per clk: the whole
// sequencer step is a single state update from the input item to the result
// register, so a new item is taken every cycle as long as the result register
// is empty or being drained in the same cycle (in_ready = !out_valid | out_ready).
// The result item is registered. An op of 1..6 is only taken while idle;
// commands that arrive while busy are dropped. Every frame first holds chip
// select high until data_out_pin reads high (device ready), then sends start
// bit, opcode and address MSB first. A write runs as three frames (enable,
// write, disable). A read repeats the full frame, with the same address, while
// the dummy zero is missing, for at most read_retries attempts in all (at least
// one); after that it reports read_failed with read_data all ones. read_retries
// is written through the cfg channel, which is always ready, and must only be
// changed while the block is idle.
module microwire_eeprom_master #(
    parameter int ADDRESS_BITS = mwee_pkg::ADDRESS_BITS_DEF,
    parameter int DATA_BITS    = mwee_pkg::DATA_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mwee_pkg::RETRIES_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  mwee_pkg::in_item_t                in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output mwee_pkg::out_item_t               out_data
);

    localparam int HEAD_BITS = ADDRESS_BITS + 2;
    localparam int MAX_BITS  = (HEAD_BITS > DATA_BITS) ? HEAD_BITS : DATA_BITS;
    localparam int CNT_W     = $clog2(MAX_BITS + 1);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT,
        PH_HEAD,
        PH_DATA,
        PH_CHECK,
        PH_READ,
        PH_END,
        PH_RESTART
    } phase_t;

    typedef enum logic [2:0] {
        K_READ,
        K_WRITE,
        K_ERASE,
        K_ERAL,
        K_EWEN,
        K_EWDS
    } kind_t;

    // Frame type for a command; a write walks enable, write, disable.
    function automatic kind_t frame_kind(input logic [2:0] op, input logic [1:0] sub);
        kind_t k;
        case (op)
            mwee_pkg::OP_READ:  k = K_READ;
            mwee_pkg::OP_WRITE: k = (sub == 2'd0) ? K_EWEN :
                                    ((sub == 2'd1) ? K_WRITE : K_EWDS);
            mwee_pkg::OP_ERASE: k = K_ERASE;
            mwee_pkg::OP_ERAL:  k = K_ERAL;
            mwee_pkg::OP_EWEN:  k = K_EWEN;
            default:            k = K_EWDS;
        endcase
        return k;
    endfunction

    // Opcode plus address bits, sent MSB first after the start bit.
    function automatic logic [HEAD_BITS-1:0] frame_head(input kind_t k,
                                                         input logic [ADDRESS_BITS-1:0] a);
        logic [HEAD_BITS-1:0] h;
        case (k)
            K_READ:  h = {mwee_pkg::OPC_READ, a};
            K_WRITE: h = {mwee_pkg::OPC_WRITE, a};
            K_ERASE: h = {mwee_pkg::OPC_ERASE, a};
            K_ERAL:  h = {mwee_pkg::OPC_EXT, mwee_pkg::EXT_ERAL, {(ADDRESS_BITS-2){1'b0}}};
            K_EWEN:  h = {mwee_pkg::OPC_EXT, mwee_pkg::EXT_EWEN, {(ADDRESS_BITS-2){1'b0}}};
            default: h = {mwee_pkg::OPC_EXT, mwee_pkg::EXT_EWDS, {(ADDRESS_BITS-2){1'b0}}};
        endcase
        return h;
    endfunction

    // Sequencer state
    phase_t                          phase_reg, phase_next;
    logic [1:0]                      sub_reg, sub_next;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic [HEAD_BITS-1:0]            head_sr_reg, head_sr_next;
    logic [DATA_BITS-1:0]            in_sr_reg, in_sr_next;
    logic [mwee_pkg::RETRIES_W-1:0]  attempt_reg, attempt_next;
    logic [2:0]                      op_reg, op_next;
    logic [ADDRESS_BITS-1:0]         addr_reg, addr_next;
    logic [DATA_BITS-1:0]            wdata_reg, wdata_next;

    logic [mwee_pkg::RETRIES_W-1:0]  retries_reg;

    // Result register
    logic                            out_valid_reg;
    mwee_pkg::out_item_t             out_data_reg;
    mwee_pkg::out_item_t             res;

    logic                            in_fire;
    logic                            pin;
    logic [mwee_pkg::RETRIES_W-1:0]  attempt_inc;
    logic [1:0]                      last_sub;
    logic [ADDRESS_BITS-1:0]         in_addr;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign pin         = in_data.data_out_pin;
    assign attempt_inc = attempt_reg + 1'b1;
    assign last_sub    = (op_reg == mwee_pkg::OP_WRITE) ? 2'd2 : 2'd0;
    assign in_addr     = ADDRESS_BITS'(in_data.address);

    // One bus period per item: pin levels and status for this period, plus
    // the sequencer's next state.
    always_comb
    begin
        phase_next   = phase_reg;
        sub_next     = sub_reg;
        cnt_next     = cnt_reg;
        head_sr_next = head_sr_reg;
        in_sr_next   = in_sr_reg;
        attempt_next = attempt_reg;
        op_next      = op_reg;
        addr_next    = addr_reg;
        wdata_next   = wdata_reg;

        res          = '0;
        res.busy_res = 1'b1;

        case (phase_reg)
            PH_IDLE:
            begin
                res.busy_res = 1'b0;
                if (in_data.op >= mwee_pkg::OP_READ && in_data.op <= mwee_pkg::OP_EWDS)
                begin
                    op_next      = in_data.op;
                    addr_next    = in_addr;
                    wdata_next   = DATA_BITS'(in_data.write_data);
                    sub_next     = 2'd0;
                    attempt_next = '0;
                    in_sr_next   = '0;
                    head_sr_next = frame_head(frame_kind(in_data.op, 2'd0), in_addr);
                    phase_next   = PH_WAIT;
                    res.busy_res = 1'b1;
                end
            end
            PH_WAIT:
            begin
                // hold CS until the device signals ready, then the start bit
                res.chip_select = 1'b1;
                if (pin)
                begin
                    res.serial_data_in = 1'b1;
                    res.clock_pulse    = 1'b1;
                    cnt_next           = CNT_W'(HEAD_BITS);
                    phase_next         = PH_HEAD;
                end
            end
            PH_HEAD:
            begin
                res.chip_select    = 1'b1;
                res.clock_pulse    = 1'b1;
                res.serial_data_in = head_sr_reg[HEAD_BITS-1];
                head_sr_next       = head_sr_reg << 1;
                cnt_next           = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    case (frame_kind(op_reg, sub_reg))
                        K_READ:  phase_next = PH_CHECK;
                        K_WRITE:
                        begin
                            cnt_next   = CNT_W'(DATA_BITS);
                            phase_next = PH_DATA;
                        end
                        default: phase_next = PH_END;
                    endcase
                end
            end
            PH_DATA:
            begin
                res.chip_select    = 1'b1;
                res.clock_pulse    = 1'b1;
                res.serial_data_in = wdata_reg[DATA_BITS-1];
                wdata_next         = wdata_reg << 1;
                cnt_next           = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    phase_next = PH_END;
                end
            end
            PH_CHECK:
            begin
                // dummy zero present: go read; otherwise count the attempt
                res.chip_select = 1'b1;
                if (!pin)
                begin
                    cnt_next   = CNT_W'(DATA_BITS);
                    in_sr_next = '0;
                    phase_next = PH_READ;
                end
                else
                begin
                    attempt_next = attempt_inc;
                    if (attempt_inc >= retries_reg || attempt_inc == '0)
                    begin
                        res.done_res    = 1'b1;
                        res.read_failed = 1'b1;
                        res.read_data   = '1;
                        phase_next      = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_RESTART;
                    end
                end
            end
            PH_RESTART:
            begin
                head_sr_next = frame_head(frame_kind(op_reg, sub_reg), addr_reg);
                phase_next   = PH_WAIT;
            end
            PH_READ:
            begin
                res.chip_select = 1'b1;
                res.clock_pulse = 1'b1;
                in_sr_next      = {in_sr_reg[DATA_BITS-2:0], pin};
                cnt_next        = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    res.done_res  = 1'b1;
                    res.read_data = mwee_pkg::RDATA_W'(in_sr_next);
                    phase_next    = PH_IDLE;
                end
            end
            PH_END:
            begin
                // CS low for one period; start the next frame of a write here
                if (sub_reg >= last_sub)
                begin
                    res.done_res = 1'b1;
                    phase_next   = PH_IDLE;
                end
                else
                begin
                    sub_next     = sub_reg + 1'b1;
                    head_sr_next = frame_head(frame_kind(op_reg, sub_reg + 1'b1), addr_reg);
                    phase_next   = PH_WAIT;
                end
            end
            default:
            begin
                res.busy_res = 1'b0;
                phase_next   = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            sub_reg       <= '0;
            cnt_reg       <= '0;
            head_sr_reg   <= '0;
            in_sr_reg     <= '0;
            attempt_reg   <= '0;
            op_reg        <= '0;
            addr_reg      <= '0;
            wdata_reg     <= '0;
            retries_reg   <= mwee_pkg::READ_RETRIES_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                retries_reg <= cfg_data;
            end
            if (in_fire)
            begin
                phase_reg     <= phase_next;
                sub_reg       <= sub_next;
                cnt_reg       <= cnt_next;
                head_sr_reg   <= head_sr_next;
                in_sr_reg     <= in_sr_next;
                attempt_reg   <= attempt_next;
                op_reg        <= op_next;
                addr_reg      <= addr_next;
                wdata_reg     <= wdata_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_data_reg <= res;
        end
    end

endmodule

[sv/mwee_checker.sv]
// Port-level checker for the serial EEPROM master, bound to the top level.
module mwee_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_ready,
    input mwee_pkg::out_item_t            out_data
);

    // a clock pulse is only issued with the device selected
    a_clk_needs_cs: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.clock_pulse |-> out_data.chip_select)
        else $error("clock pulse without chip select");

    // a failed read finishes the command and returns all ones
    a_fail_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.read_failed |->
            out_data.done_res && out_data.busy_res && (out_data.read_data == '1))
        else $error("read failure without done or all-ones data");

    // an idle period drives no pins
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.busy_res |->
            !out_data.chip_select && !out_data.clock_pulse && !out_data.done_res)
        else $error("pin activity while idle");

    // a stalled item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result item changed while stalled");

endmodule

bind microwire_eeprom_master mwee_checker u_mwee_checker (.*);
